// ===== rtl/core/tlsdt_pkg.sv =====
package tlsdt_pkg;

  // table geometry
  localparam int TLS_SLOTS       = 3;
  localparam int FIRST_TLS_ENTRY = 6;
  localparam int SLOT_W          = (TLS_SLOTS > 1) ? $clog2(TLS_SLOTS) : 1;
  localparam int DESC_W          = 64;

  // field widths
  localparam int IDX_W    = 9;
  localparam int STATUS_W = 2;
  localparam int IN_DW    = 80;
  localparam int OUT_DW   = 80;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_NO_SLOT = 2'd2
  } status_t;

  // request kinds carried on tuser
  localparam logic MODE_SET   = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

endpackage

// ===== rtl/core/tlsdt_ram.sv =====
module tlsdt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/tls_segment_descriptor_table_top.sv =====
// channel | beat contents (lowest bit first)                   | role
// in_     | tuser: mode; tdata: indexes, base, limit, flags   | request
// out_    | tdata: status, final entry, descriptor low, high  | result
//
// a request holds the block from accept until it returns to idle, so no new request is
// taken before the last one is through; a free-slot search reads one table entry per cycle from the descriptor ram
// the result register loads in S_DONE, reached through S_EXEC and, with a search, S_SCAN
// synchronous active-low reset marks every slot empty through per-slot valid bits
// a result waiting on out_tready does not block the next request beat; the block
// holds in its final state only while the previous result is still unconsumed
module tls_segment_descriptor_table_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // mode
  input  logic                      in_tuser,
  // call_index[8:0], entry_num[17:9], base_address[49:18], segment_limit[69:50],
  // contents_kind[71:70], rx_only[72], seg_is_32bit[73], page_granular[74],
  // not_present[75], useable[76], alloc_en[77], zero fill[79:78]
  input  logic [tlsdt_pkg::IN_DW-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // status[1:0], final_entry[10:2], descriptor_low[42:11], descriptor_high[74:43],
  // zero fill[79:75]
  output logic [tlsdt_pkg::OUT_DW-1:0] out_tdata
);

  import tlsdt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } state_t;

  localparam logic [IDX_W-1:0]  IDX_NONE  = '1;
  localparam logic [IDX_W-1:0]  IDX_FIRST = IDX_W'(FIRST_TLS_ENTRY);
  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(FIRST_TLS_ENTRY + TLS_SLOTS - 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TLS_SLOTS - 1);

  // input field unpacking
  logic [IDX_W-1:0] f_call_index;
  logic [IDX_W-1:0] f_entry_num;
  logic [31:0]      f_base;
  logic [19:0]      f_limit;
  logic [1:0]       f_contents;
  logic             f_rx_only;
  logic             f_is32;
  logic             f_pages;
  logic             f_not_present;
  logic             f_avl;
  logic             f_can_alloc;

  assign f_call_index   = in_tdata[8:0];
  assign f_entry_num    = in_tdata[17:9];
  assign f_base         = in_tdata[49:18];
  assign f_limit        = in_tdata[69:50];
  assign f_contents     = in_tdata[71:70];
  assign f_rx_only      = in_tdata[72];
  assign f_is32         = in_tdata[73];
  assign f_pages        = in_tdata[74];
  assign f_not_present  = in_tdata[75];
  assign f_avl          = in_tdata[76];
  assign f_can_alloc    = in_tdata[77];

  state_t                  state_r;
  logic                    req_mode_r;
  logic [IDX_W-1:0]        req_idx_r;
  logic                    req_alloc_r;
  logic [DESC_W-1:0]       req_desc_r;
  logic [SLOT_W-1:0]       slot_r;
  logic [TLS_SLOTS-1:0]    valid_r;
  status_t                 res_status_r;
  logic [IDX_W-1:0]        res_entry_r;
  logic [DESC_W-1:0]       res_desc_r;
  logic                    out_vld_r;
  logic [OUT_DW-1:0]       out_data_r;

  logic                    accept;
  logic [IDX_W-1:0]        idx_sel;
  logic                    is_empty_pat;
  logic [31:0]             desc_lo;
  logic [31:0]             desc_hi;
  logic [IDX_W-1:0]        idx_off;
  logic [SLOT_W-1:0]       exec_slot;
  logic                    in_range;
  logic                    slot_free;
  logic                    out_free;

  logic                    ram_we;
  logic [SLOT_W-1:0]       ram_waddr;
  logic                    ram_re;
  logic [SLOT_W-1:0]       ram_raddr;
  logic [DESC_W-1:0]       ram_rdata;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_vld_r || out_tready;

  // entry selection and descriptor packing
  assign idx_sel      = (f_call_index == IDX_NONE) ? f_entry_num : f_call_index;
  assign is_empty_pat = (f_base == '0) && (f_limit == '0) && (f_contents == '0) &&
                        f_rx_only && !f_is32 && !f_pages && f_not_present && !f_avl;
  assign desc_lo      = {f_base[15:0], f_limit[15:0]};
  assign desc_hi      = {f_base[31:24], f_pages, f_is32, 1'b0, f_avl, f_limit[19:16],
                         ~f_not_present, 2'b11, 1'b1, f_contents, ~f_rx_only, 1'b0,
                         f_base[23:16]};

  // slot range check on the resolved index
  assign idx_off   = req_idx_r - IDX_FIRST;
  assign exec_slot = idx_off[SLOT_W-1:0];
  assign in_range  = ($signed(req_idx_r) >= $signed(IDX_FIRST)) &&
                     ($signed(req_idx_r) <= $signed(IDX_LAST));

  // a slot is free when its valid bit is clear since the last clear or its entry reads as zero
  assign slot_free = !valid_r[slot_r] || (ram_rdata == '0);

  // descriptor RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = exec_slot;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state_r)
      S_EXEC: begin
        if (req_mode_r == MODE_SET) begin
          if (req_alloc_r) begin
            ram_re = 1'b1;
          end else if (in_range) begin
            ram_we = 1'b1;
          end
        end
      end
      S_SCAN: begin
        ram_waddr = slot_r;
        ram_raddr = slot_r + SLOT_W'(1);
        if (slot_free) begin
          ram_we = 1'b1;
        end else if (slot_r != SLOT_LAST) begin
          ram_re = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  tlsdt_ram #(
    .WIDTH(DESC_W),
    .DEPTH(TLS_SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(req_desc_r),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // request sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      // result valid set on load, dropped once taken
      if (state_r == S_DONE && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            req_mode_r  <= in_tuser;
            req_idx_r   <= idx_sel;
            req_alloc_r <= (idx_sel == IDX_NONE) && f_can_alloc;
            req_desc_r  <= is_empty_pat ? '0 : {desc_hi, desc_lo};
            state_r     <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (req_mode_r == MODE_CLEAR) begin
            valid_r      <= '0;
            res_status_r <= STATUS_OK;
            res_entry_r  <= '0;
            res_desc_r   <= '0;
            state_r      <= S_DONE;
          end else if (req_alloc_r) begin
            res_status_r <= STATUS_OK;
            res_desc_r   <= '0;
            slot_r       <= '0;
            state_r      <= S_SCAN;
          end else if (in_range) begin
            valid_r[exec_slot] <= 1'b1;
            res_status_r       <= STATUS_OK;
            res_entry_r        <= req_idx_r;
            res_desc_r         <= req_desc_r;
            state_r            <= S_DONE;
          end else begin
            res_status_r <= STATUS_INVALID;
            res_entry_r  <= req_idx_r;
            res_desc_r   <= '0;
            state_r      <= S_DONE;
          end
        end
        S_SCAN: begin
          if (slot_free) begin
            valid_r[slot_r] <= 1'b1;
            res_entry_r     <= IDX_FIRST + IDX_W'(slot_r);
            res_desc_r      <= req_desc_r;
            state_r         <= S_DONE;
          end else if (slot_r == SLOT_LAST) begin
            res_status_r <= STATUS_NO_SLOT;
            res_entry_r  <= IDX_NONE;
            state_r      <= S_DONE;
          end else begin
            slot_r <= slot_r + SLOT_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_data_r <= {5'b0, res_desc_r[63:32], res_desc_r[31:0], res_entry_r,
                           res_status_r};
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/core/tlsdt_checker.sv =====
module tlsdt_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [tlsdt_pkg::OUT_DW-1:0] out_tdata
);

  import tlsdt_pkg::*;

  logic [STATUS_W-1:0] st;
  logic [31:0]         lo;
  logic [31:0]         hi;

  assign st = out_tdata[1:0];
  assign lo = out_tdata[42:11];
  assign hi = out_tdata[74:43];

  // a stalled result beat keeps its data
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result beat changed while stalled");

  // only defined status codes leave the block
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (st == STATUS_OK || st == STATUS_INVALID || st == STATUS_NO_SLOT))
    else $error("undefined status code");

  // failed requests carry no descriptor
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st != STATUS_OK |-> (lo == '0 && hi == '0))
    else $error("descriptor on failed request");

  // a written descriptor is a user code or data segment with L clear
  a_desc_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == STATUS_OK && (lo != '0 || hi != '0) |->
      (hi[14:12] == 3'b111 && hi[21] == 1'b0))
    else $error("descriptor fixed bits wrong");

endmodule

bind tls_segment_descriptor_table_top tlsdt_checker u_tlsdt_checker (.*);
